FILE: hw/rtl/lrupr_pkg.sv
package lrupr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int FAULT_W = 32;
    localparam int CFG_W   = 4;

    localparam int APB_DW = 32;
    localparam int APB_AW = 1;

    localparam logic [APB_AW-1:0] ADDR_FRAMES_IN_USE = 1'b0;
    localparam logic [CFG_W-1:0]  FRAMES_IN_USE_RST  = 4'd8;

endpackage

FILE: hw/rtl/lru_page_replacement.sv
// channel  | handshake             | payload
// ---------+-----------------------+-----------------------------------------------
// in       | in_valid / in_stall   | page
// out      | out_valid / out_stall | hit, frame, evicted_valid, evicted_page,
//          |                       | fault_count
// cfg      | apb psel/penable      | frames_in_use at address 0
//
// one reference per clock unless a stalled result holds the pipe; a beat is captured in the
// input register and then moves on into the result register.
// the frame search, victim pick and rank update are combinational on the frame state.
// reset clears valid bits, ranks, fault count and the valid flags of both pipeline registers.
// a stalled result holds the input register; in_stall rises only when both are full.
module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int  FRAMES    = FRAMES_DEF,
    parameter int  PAGE_BITS = PAGE_BITS_DEF,
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [PAGE_BITS-1:0] page,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic [IDX_W-1:0]     frame,
    output logic                 evicted_valid,
    output logic [PAGE_BITS-1:0] evicted_page,
    output logic [FAULT_W-1:0]   fault_count,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    logic [CFG_W-1:0]     frames_cfg_reg;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [PAGE_BITS-1:0] s1_page_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 hit_reg;
    logic [IDX_W-1:0]     frame_reg;
    logic                 evicted_valid_reg;
    logic [PAGE_BITS-1:0] evicted_page_reg;
    logic [FAULT_W-1:0]   fault_count_reg;

    logic                 advance;
    logic                 in_fire;

    logic                 c_hit;
    logic [IDX_W-1:0]     c_frame;
    logic                 c_evicted_valid;
    logic [PAGE_BITS-1:0] c_evicted_page;
    logic [FAULT_W-1:0]   c_fault_count;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_cfg_reg <= FRAMES_IN_USE_RST;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_FRAMES_IN_USE))
        begin
            frames_cfg_reg <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_FRAMES_IN_USE) ? APB_DW'(frames_cfg_reg) : '0;

    // the input beat moves on whenever the result register is free or draining
    assign advance  = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_page_reg <= page;
        end
        if (advance)
        begin
            hit_reg           <= c_hit;
            frame_reg         <= c_frame;
            evicted_valid_reg <= c_evicted_valid;
            evicted_page_reg  <= c_evicted_page;
            fault_count_reg   <= c_fault_count;
        end
    end

    lrupr_frames #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_frames (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .page          (s1_page_reg),
        .frames_cfg    (frames_cfg_reg),
        .hit           (c_hit),
        .frame         (c_frame),
        .evicted_valid (c_evicted_valid),
        .evicted_page  (c_evicted_page),
        .fault_count   (c_fault_count)
    );

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign frame         = frame_reg;
    assign evicted_valid = evicted_valid_reg;
    assign evicted_page  = evicted_page_reg;
    assign fault_count   = fault_count_reg;

endmodule

FILE: hw/rtl/lrupr_frames.sv
module lrupr_frames
    import lrupr_pkg::*;
#(
    parameter int  FRAMES    = FRAMES_DEF,
    parameter int  PAGE_BITS = PAGE_BITS_DEF,
    localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int CNT_W     = $clog2(FRAMES + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [PAGE_BITS-1:0] page,
    input  logic [CFG_W-1:0]     frames_cfg,
    output logic                 hit,
    output logic [IDX_W-1:0]     frame,
    output logic                 evicted_valid,
    output logic [PAGE_BITS-1:0] evicted_page,
    output logic [FAULT_W-1:0]   fault_count
);

    logic [PAGE_BITS-1:0] pages_reg [FRAMES];
    logic [FRAMES-1:0]    valid_reg;
    logic [FRAMES-1:0]    valid_next;
    logic [IDX_W-1:0]     rank_reg  [FRAMES];
    logic [IDX_W-1:0]     rank_next [FRAMES];
    logic [FAULT_W-1:0]   faults_reg;
    logic [FAULT_W-1:0]   faults_next;

    logic [CNT_W-1:0]     active_n;
    logic [FRAMES-1:0]    act_mask;
    logic [FRAMES-1:0]    live;
    logic [FRAMES-1:0]    match;
    logic [FRAMES-1:0]    empty;
    logic [IDX_W-1:0]     hit_idx;
    logic [IDX_W-1:0]     empty_idx;
    logic [IDX_W-1:0]     victim_idx;
    logic [IDX_W-1:0]     best_rank;
    logic [IDX_W-1:0]     sel;
    logic                 fresh;
    logic                 evict;
    logic [IDX_W:0]       old_rank;

    // zero acts as one frame, anything above the frame count is clipped
    always_comb
    begin
        if (frames_cfg == '0)
        begin
            active_n = CNT_W'(1);
        end
        else if (32'(frames_cfg) > FRAMES)
        begin
            active_n = CNT_W'(FRAMES);
        end
        else
        begin
            active_n = CNT_W'(frames_cfg);
        end
    end

    always_comb
    begin
        for (int f = 0; f < FRAMES; f++)
        begin
            act_mask[f] = (f < int'(active_n));
            live[f]     = valid_reg[f] && act_mask[f];
            match[f]    = live[f] && (pages_reg[f] == page);
            empty[f]    = !valid_reg[f] && act_mask[f];
        end
    end

    // lowest-numbered match and lowest-numbered empty frame
    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        for (int f = FRAMES - 1; f >= 0; f--)
        begin
            if (match[f])
            begin
                hit_idx = IDX_W'(f);
            end
            if (empty[f])
            begin
                empty_idx = IDX_W'(f);
            end
        end
    end

    // oldest active frame, ties to the lower index
    always_comb
    begin
        victim_idx = '0;
        best_rank  = rank_reg[0];
        for (int f = 1; f < FRAMES; f++)
        begin
            if (act_mask[f] && (rank_reg[f] > best_rank))
            begin
                victim_idx = IDX_W'(f);
                best_rank  = rank_reg[f];
            end
        end
    end

    assign hit   = |match;
    assign fresh = !hit && (|empty);
    assign evict = !hit && !(|empty);

    always_comb
    begin
        if (hit)
        begin
            sel = hit_idx;
        end
        else if (fresh)
        begin
            sel = empty_idx;
        end
        else
        begin
            sel = victim_idx;
        end
    end

    // a newly filled frame is older than every other
    assign old_rank = fresh ? (IDX_W + 1)'(FRAMES) : {1'b0, rank_reg[sel]};

    always_comb
    begin
        valid_next = valid_reg;
        valid_next[sel] = 1'b1;
        for (int g = 0; g < FRAMES; g++)
        begin
            rank_next[g] = rank_reg[g];
            if ((IDX_W'(g) != sel) && live[g] && ({1'b0, rank_reg[g]} < old_rank)
                && (rank_reg[g] != IDX_W'(FRAMES - 1)))
            begin
                rank_next[g] = rank_reg[g] + 1'b1;
            end
        end
        rank_next[sel] = '0;
    end

    always_comb
    begin
        faults_next = faults_reg;
        if (!hit && (faults_reg != '1))
        begin
            faults_next = faults_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            faults_reg <= '0;
            for (int f = 0; f < FRAMES; f++)
            begin
                rank_reg[f] <= '0;
            end
        end
        else if (step)
        begin
            valid_reg  <= valid_next;
            faults_reg <= faults_next;
            for (int f = 0; f < FRAMES; f++)
            begin
                rank_reg[f] <= rank_next[f];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && !hit)
        begin
            pages_reg[sel] <= page;
        end
    end

    assign frame         = sel;
    assign evicted_valid = evict;
    assign evicted_page  = evict ? pages_reg[victim_idx] : '0;
    assign fault_count   = faults_next;

endmodule

FILE: hw/rtl/lrupr_checker.sv
module lrupr_checker
    import lrupr_pkg::*;
#(
    parameter int PAGE_BITS = PAGE_BITS_DEF,
    parameter int IDX_W     = 3
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic                 hit,
    input logic [IDX_W-1:0]     frame,
    input logic                 evicted_valid,
    input logic [PAGE_BITS-1:0] evicted_page,
    input logic [FAULT_W-1:0]   fault_count
);

    logic out_beat;

    assign out_beat = out_valid && !out_stall;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame) && $stable(fault_count))
        else $error("stalled result changed");

    a_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && evicted_valid) && (evicted_valid || (evicted_page == '0)))
        else $error("eviction fields inconsistent with hit");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat ##1 out_valid |-> fault_count >= $past(fault_count))
        else $error("fault count went backwards");

    a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_beat ##1 (out_valid && hit) |-> fault_count == $past(fault_count))
        else $error("fault count moved on a hit");

endmodule

bind lru_page_replacement lrupr_checker #(
    .PAGE_BITS (PAGE_BITS),
    .IDX_W     (IDX_W)
) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .frame         (frame),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_count   (fault_count)
);

FILE: verif/lru_replacement_checker.sv
`timescale 1ns / 1ps

module lru_replacement_checker
    import lrupr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [PAGE_BITS_DEF-1:0] page,

    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic                     hit,
    input  logic [2:0]               frame,
    input  logic                     evicted_valid,
    input  logic [PAGE_BITS_DEF-1:0] evicted_page,
    input  logic [FAULT_W-1:0]       fault_count,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_AW-1:0]        paddr,
    input  logic [APB_DW-1:0]        pwdata,
    input  logic [APB_DW-1:0]        prdata,
    input  logic                     pready,

    output int                       pending,
    output int                       errors,
    output int                       refs_seen,
    output int                       hits_seen,
    output int                       evictions_seen
);

    typedef struct packed {
        logic                     hit;
        logic [2:0]               frame;
        logic                     evicted_valid;
        logic [PAGE_BITS_DEF-1:0] evicted_page;
        logic [FAULT_W-1:0]       fault_count;
    } lru_result_t;

    // shadow of the frame table and the frame-count register
    logic [PAGE_BITS_DEF-1:0] resident_page [FRAMES_DEF];
    bit                       resident      [FRAMES_DEF];
    bit   [2:0]               age           [FRAMES_DEF];
    bit   [FAULT_W-1:0]       faults;
    bit   [CFG_W-1:0]         frames_reg;

    lru_result_t              awaited_results [$];
    lru_result_t              want;

    function automatic lru_result_t replace_page(logic [PAGE_BITS_DEF-1:0] p);
        int          n;
        int          sel;
        int          old_age;
        bit          found;
        bit          empty;
        lru_result_t r;
        n = int'(frames_reg);
        if (n == 0)
            n = 1;
        if (n > FRAMES_DEF)
            n = FRAMES_DEF;
        r = '0;
        sel = 0;
        found = 1'b0;
        empty = 1'b0;
        for (int f = 0; f < n; f++)
        begin
            if (!found && resident[f] && resident_page[f] == p)
            begin
                sel = f;
                found = 1'b1;
            end
        end
        if (found)
        begin
            r.hit = 1'b1;
            old_age = int'(age[sel]);
        end
        else
        begin
            for (int f = 0; f < n; f++)
            begin
                if (!empty && !resident[f])
                begin
                    sel = f;
                    empty = 1'b1;
                end
            end
            if (empty)
            begin
                // a fresh frame is older than everything else
                resident[sel] = 1'b1;
                old_age = FRAMES_DEF;
            end
            else
            begin
                sel = 0;
                for (int f = 1; f < n; f++)
                    if (age[f] > age[sel])
                        sel = f;
                r.evicted_valid = 1'b1;
                r.evicted_page = resident_page[sel];
                old_age = int'(age[sel]);
            end
            resident_page[sel] = p;
            if (faults != '1)
                faults++;
        end
        for (int g = 0; g < n; g++)
            if (g != sel && resident[g] && int'(age[g]) < old_age
                && int'(age[g]) < FRAMES_DEF - 1)
                age[g]++;
        age[sel] = '0;
        r.frame = sel[2:0];
        r.fault_count = faults;
        return r;
    endfunction

    function automatic void check_field(string what, logic [31:0] exp_v, logic [31:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int f = 0; f < FRAMES_DEF; f++)
            begin
                resident_page[f] = '0;
                resident[f] = 1'b0;
                age[f] = '0;
            end
            faults = '0;
            frames_reg = FRAMES_IN_USE_RST;
            awaited_results.delete();
            pending = 0;
            errors = 0;
            refs_seen = 0;
            hits_seen = 0;
            evictions_seen = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, actual frame %0d hit %0b",
                             $time, frame, hit);
                    errors++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("hit", 32'(want.hit), 32'(hit));
                    check_field("frame", 32'(want.frame), 32'(frame));
                    check_field("evicted_valid", 32'(want.evicted_valid), 32'(evicted_valid));
                    check_field("evicted_page", 32'(want.evicted_page), 32'(evicted_page));
                    check_field("fault_count", want.fault_count, fault_count);
                    refs_seen++;
                    hits_seen += int'(want.hit);
                    evictions_seen += int'(want.evicted_valid);
                end
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(replace_page(page));
            if (psel && penable && pready && paddr == ADDR_FRAMES_IN_USE)
            begin
                if (pwrite)
                    frames_reg = pwdata[CFG_W-1:0];
                else
                    check_field("prdata", {{(APB_DW-CFG_W){1'b0}}, frames_reg}, prdata);
            end
            pending = awaited_results.size();
        end
    end

endmodule

FILE: verif/tb_lru_page_replacement.sv
`timescale 1ns / 1ps

module tb_lru_page_replacement;
    import lrupr_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 175;
    localparam int IDLE_LIMIT   = 2000;

    logic                     clk = 1'b0;
    logic                     rst_n;

    logic                     in_valid;
    logic                     in_stall;
    logic [PAGE_BITS_DEF-1:0] page;

    logic                     out_valid;
    logic                     out_stall;
    logic                     hit;
    logic [2:0]               frame;
    logic                     evicted_valid;
    logic [PAGE_BITS_DEF-1:0] evicted_page;
    logic [FAULT_W-1:0]       fault_count;

    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_AW-1:0]        paddr;
    logic [APB_DW-1:0]        pwdata;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    int                       pending;
    int                       errors;
    int                       refs_seen;
    int                       hits_seen;
    int                       evictions_seen;

    int                       idle_cycles;
    int                       settings_used;
    bit                       calm;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    lru_page_replacement dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .page          (page),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .hit           (hit),
        .frame         (frame),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    lru_replacement_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .page           (page),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .hit            (hit),
        .frame          (frame),
        .evicted_valid  (evicted_valid),
        .evicted_page   (evicted_page),
        .fault_count    (fault_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .pending        (pending),
        .errors         (errors),
        .refs_seen      (refs_seen),
        .hits_seen      (hits_seen),
        .evictions_seen (evictions_seen)
    );

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // all tasks are entered and left at a falling edge
    task automatic send_page(input logic [PAGE_BITS_DEF-1:0] p);
        in_valid <= 1'b1;
        page <= p;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    task automatic apb_access(input bit wr, input logic [CFG_W-1:0] v);
        psel <= 1'b1;
        pwrite <= wr;
        paddr <= ADDR_FRAMES_IN_USE;
        pwdata <= ($urandom() & 32'hFFFF_FFF0) | APB_DW'(v);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // only with the pipeline drained: wait out every result, then the latency
    task automatic set_frames(input logic [CFG_W-1:0] v);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        apb_access(1'b1, v);
        apb_access(1'b0, '0);
        settings_used++;
    endtask

    // result-side back-pressure
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(negedge clk);
        forever
        begin
            n = gap_len();
            if (calm || n == 0)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (psel && penable && pready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [PAGE_BITS_DEF-1:0] base;
        logic [CFG_W-1:0]         v;
        int                       span;
        int                       extremes [4];
        rst_n = 1'b0;
        in_valid = 1'b0;
        page = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm = 1'b1;
        settings_used = 0;
        idle_cycles = 0;
        extremes = '{1, 8, 0, 15};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // above the frame count: behaves as eight frames; fill in order, then hits and LRU
        set_frames(4'd15);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h0001);
        send_page(16'h8000);
        send_page(16'h1234);
        send_page(16'h00FF);
        send_page(16'hFFFF);
        send_page(16'h0000);
        send_page(16'h4321);
        send_page(16'h5555);
        // zero acts as one frame; other frames keep their pages
        set_frames(4'd0);
        send_page(16'h4321);
        send_page(16'h0000);
        send_page(16'h8000);
        // grow back: the same page now sits in two frames
        set_frames(4'd8);
        send_page(16'h8000);
        send_page(16'h2222);
        send_page(16'h3333);
        send_page(16'hAAAA);
        // shrink and grow again so ranks of idle frames tie
        set_frames(4'd2);
        send_page(16'h7777);
        send_page(16'h6666);
        set_frames(4'd8);
        send_page(16'h9999);
        send_page(16'hBBBB);
        send_page(16'hCCCC);

        calm = 1'b0;
        base = PAGE_BITS_DEF'($urandom_range(0, 65535));
        for (int ph = 0; ph < PHASES; ph++)
        begin
            v = (ph < 4) ? CFG_W'(extremes[ph]) : CFG_W'($urandom_range(0, 15));
            set_frames(v);
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
                base = PAGE_BITS_DEF'($urandom_range(0, 65535));
            span = ((v == 0) ? 1 : (v > 8) ? 8 : int'(v)) + int'($urandom_range(0, 4));
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (!calm)
                    pause_sender(gap_len());
                if ($urandom_range(0, 9) == 0)
                    send_page(PAGE_BITS_DEF'($urandom_range(0, 65535)));
                else
                    send_page(PAGE_BITS_DEF'(32'(base) + $urandom_range(0, span)));
            end
        end

        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(posedge clk);

        $display("run checked %0d page references: %0d hits, %0d evictions",
                 refs_seen, hits_seen, evictions_seen);
        $display("over %0d frame-count settings, including zero, one, eight and fifteen",
                 settings_used);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
